[sv/ppvc_pkg.sv]
// Package for the pose PI velocity controller: payload structs, command codes,
// register indexes and fixed widths. No dependencies.
package ppvc_pkg;
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_IDLE   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_STOP_DIST  = 3'd0;
    localparam logic [2:0] REG_STOP_ANGLE = 3'd1;
    localparam logic [2:0] REG_SPEED      = 3'd2;
    localparam logic [2:0] REG_TURN       = 3'd3;
    localparam logic [2:0] REG_GAIN_P     = 3'd4;
    localparam logic [2:0] REG_GAIN_I     = 3'd5;

    localparam int CFG_W = 31;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               follow_mode;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [18:0]        goal_heading;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [19:0] meas_heading;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] turn_rate;
        logic               reached;
        logic               running;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] stop_distance;
        logic [CFG_W-1:0] stop_angle;
        logic [CFG_W-1:0] speed_limit;
        logic [CFG_W-1:0] turn_limit;
        logic [CFG_W-1:0] gain_prop;
        logic [CFG_W-1:0] gain_integ;
    } t_cfg;
endpackage

[sv/ppvc_front.sv]
// Front end: takes input words, drops unused commands and queues the rest in a
// two-entry FIFO for the back end. Depends on ppvc_pkg.
module ppvc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ppvc_pkg::t_in_word i_word,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output ppvc_pkg::t_in_word o_q_word
);
    import ppvc_pkg::*;

    t_in_word   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_pop     = i_q_pop && (r_cnt != 2'd0);
    // drop the unused command code right here
    assign w_push    = i_valid && !o_stall && (i_word.cmd != CMD_UNUSED);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[sv/ppvc_back.sv]
// Back end: sequencer with one shared 32x32 gain multiplier and a restoring divider
// with numerator products for the joint speed scaling. Depends on ppvc_pkg.
module ppvc_back #(
    parameter int POS_FRAC_BITS  = 16,
    parameter int GAIN_FRAC_BITS = 20,
    parameter int INTEG_WIDTH    = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppvc_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  ppvc_pkg::t_in_word  i_q_word,
    output logic                o_valid,
    input  logic                i_stall,
    output ppvc_pkg::t_out_word o_word
);
    import ppvc_pkg::*;

    localparam int IW = INTEG_WIDTH;
    localparam int EW = 34;
    // pi rounded to POS_FRAC_BITS fraction bits (from a Q62 constant)
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_RND =
        (PI_Q62 + (64'd1 << (61 - POS_FRAC_BITS))) >> (62 - POS_FRAC_BITS);
    localparam logic signed [EW-1:0] PI_Q   = EW'(PI_RND);
    localparam logic signed [EW-1:0] TWO_PI = EW'(PI_RND << 1);
    localparam logic signed [IW-1:0] IHI = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] ILO = {1'b1, {(IW-1){1'b0}}};
    localparam logic [63:0] TERM_LIM = 64'd1 << 60;
    localparam int MW = (IW > 32) ? IW : 32;
    localparam int PW = MW + 32;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_WRAP = 4'd2;
    localparam logic [3:0] S_INT  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_LIM  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]  r_state;
    logic signed [31:0] r_tx, r_ty;
    logic [18:0] r_th;
    logic        r_follow, r_active;
    logic signed [IW-1:0] r_ix, r_iy, r_ih;
    logic signed [31:0] r_lvx, r_lvy, r_lw;
    logic signed [EW-1:0] r_ex, r_ey, r_eh, r_u;
    logic [1:0]  r_axis;
    logic        r_phase, r_reached;
    logic        r_half;
    logic [63:0] r_plo;
    logic signed [63:0] r_pterm;
    logic signed [31:0] r_vx, r_vy, r_w;
    logic [5:0]  r_dcnt;
    logic [62:0] r_num;
    logic [31:0] r_den, r_quo;
    logic [31:0] r_rem;
    logic        r_dsel;
    logic        r_ovalid;
    t_out_word   r_oword;

    logic signed [EW-1:0] w_e;
    logic signed [IW-1:0] w_acc, w_sum;
    logic        w_neg;
    logic [MW-1:0] w_mag;
    logic [31:0] w_g;
    logic [31:0] w_msel;
    logic [63:0] w_mul;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_shr;
    logic [63:0] w_term;
    logic signed [64:0] w_tot;
    logic signed [31:0] w_sat;
    logic [31:0] w_ax, w_ay, w_m;
    logic [32:0] w_trial;
    logic [31:0] w_qnext;

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && !r_ovalid;

    always_comb begin
        case (r_axis)
            2'd0:    begin w_e = r_ex; w_acc = r_ix; end
            2'd1:    begin w_e = r_ey; w_acc = r_iy; end
            default: begin w_e = r_eh; w_acc = r_ih; end
        endcase
    end

    // saturating integrator add
    always_comb begin
        logic signed [IW:0] s;
        s = {w_acc[IW-1], w_acc} + (IW+1)'(w_e);
        if (s > (IW+1)'(IHI))      w_sum = IHI;
        else if (s < (IW+1)'(ILO)) w_sum = ILO;
        else                       w_sum = s[IW-1:0];
    end

    // shared gain multiplier: phase 0 = P*e, phase 1 = I*acc
    always_comb begin
        logic signed [IW-1:0] v;
        v     = r_phase ? w_acc : IW'(w_e);
        w_neg = v[IW-1];
        w_mag = MW'(w_neg ? -{1'b0, v} : {1'b0, v});
        w_g   = r_phase ? {1'b0, i_cfg.gain_integ} : {1'b0, i_cfg.gain_prop};
        // low 32 bits of the magnitude first, the upper bits on the next cycle
        w_msel = r_half ? 32'(w_mag >> 32) : w_mag[31:0];
        w_mul  = w_msel * w_g;
        w_prod = PW'(r_plo) + (PW'(w_mul) << 32);
        w_shr  = w_prod >> GAIN_FRAC_BITS;
        if (w_shr > PW'(TERM_LIM)) w_term = TERM_LIM;
        else                       w_term = w_shr[63:0];
        if (w_neg) w_term = -w_term;
        w_tot = {r_pterm[63], r_pterm} + {w_term[63], w_term};
        if (w_tot > 65'sd2147483647)       w_sat = 32'sh7fffffff;
        else if (w_tot < -65'sd2147483648) w_sat = 32'sh80000000;
        else                               w_sat = w_tot[31:0];
    end

    assign w_ax = r_vx[31] ? 32'(-r_vx) : r_vx;
    assign w_ay = r_vy[31] ? 32'(-r_vy) : r_vy;
    assign w_m  = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_trial = {r_rem, r_num[62]} - {1'b0, r_den};
    assign w_qnext = {r_quo[30:0], ~w_trial[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_active <= 1'b0; r_follow <= 1'b0;
            r_tx <= '0; r_ty <= '0; r_th <= '0;
            r_ix <= '0; r_iy <= '0; r_ih <= '0;
            r_lvx <= '0; r_lvy <= '0; r_lw <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_q_pop) begin
                    r_reached <= 1'b0;
                    case (i_q_word.cmd)
                        CMD_LOAD: begin
                            r_follow <= i_q_word.follow_mode;
                            r_tx <= i_q_word.goal_x; r_ty <= i_q_word.goal_y;
                            r_th <= i_q_word.goal_heading; r_active <= 1'b1;
                        end
                        CMD_IDLE: r_active <= 1'b0;
                        CMD_TICK: begin
                            if (!r_active) begin
                                r_ix <= '0; r_iy <= '0; r_ih <= '0;
                                r_lvx <= '0; r_lvy <= '0; r_lw <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_ex <= EW'(r_tx) - EW'(i_q_word.meas_x);
                                r_ey <= EW'(r_ty) - EW'(i_q_word.meas_y);
                                r_u  <= EW'(i_q_word.meas_heading) + PI_Q
                                        - EW'({1'b0, r_th});
                                r_state <= S_WRAP;
                            end
                        end
                        default: ;
                    endcase
                end
                S_WRAP: begin
                    // fold into [0, 2pi) one step per cycle
                    if (r_u < 0)
                        r_u <= r_u + TWO_PI;
                    else if (r_u >= TWO_PI)
                        r_u <= r_u - TWO_PI;
                    else begin
                        r_eh <= PI_Q - r_u;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    // stop check on absolute errors (skipped in follow mode)
                    if (!r_follow
                        && ((r_ex < 0 ? -r_ex : r_ex) < EW'(i_cfg.stop_distance))
                        && ((r_ey < 0 ? -r_ey : r_ey) < EW'(i_cfg.stop_distance))
                        && ((r_eh < 0 ? -r_eh : r_eh) < EW'(i_cfg.stop_angle))) begin
                        r_active <= 1'b0; r_reached <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_axis <= 2'd0; r_state <= S_INT;
                    end
                end
                S_INT: begin
                    case (r_axis)
                        2'd0:    r_ix <= w_sum;
                        2'd1:    r_iy <= w_sum;
                        default: r_ih <= w_sum;
                    endcase
                    r_phase <= 1'b0; r_pterm <= '0; r_half <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_half) begin
                        r_plo <= w_mul; r_half <= 1'b1;
                    end else begin
                        r_pterm <= w_term; r_phase <= 1'b1; r_half <= 1'b0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_half) begin
                        r_plo <= w_mul; r_half <= 1'b1;
                    end else begin
                        r_half <= 1'b0;
                        case (r_axis)
                            2'd0:    r_vx <= w_sat;
                            2'd1:    r_vy <= w_sat;
                            default: r_w  <= w_sat;
                        endcase
                        if (r_axis == 2'd2) r_state <= S_LIM;
                        else begin r_axis <= r_axis + 2'd1; r_state <= S_INT; end
                    end
                end
                S_LIM: begin
                    if (r_w > $signed({1'b0, i_cfg.turn_limit}))
                        r_w <= $signed({1'b0, i_cfg.turn_limit});
                    else if (r_w < -$signed({1'b0, i_cfg.turn_limit}))
                        r_w <= -$signed({1'b0, i_cfg.turn_limit});
                    if (w_ax > {1'b0, i_cfg.speed_limit}
                        || w_ay > {1'b0, i_cfg.speed_limit}) begin
                        r_den <= w_m; r_dsel <= 1'b0; r_dcnt <= 6'd0;
                        r_num <= 63'(w_ax) * 63'(i_cfg.speed_limit);
                        r_rem <= '0; r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                        r_lvx <= r_vx; r_lvy <= r_vy;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle; the last bit lands with the result
                    if (r_dcnt != 6'd62) begin
                        if (!w_trial[32]) r_rem <= w_trial[31:0];
                        else              r_rem <= {r_rem[30:0], r_num[62]};
                        r_quo  <= w_qnext;
                        r_num  <= {r_num[61:0], 1'b0};
                        r_dcnt <= r_dcnt + 6'd1;
                    end else if (!r_dsel) begin
                        r_lvx <= r_vx[31] ? -$signed(w_qnext) : $signed(w_qnext);
                        r_dsel <= 1'b1; r_dcnt <= 6'd0; r_rem <= '0;
                        r_num <= 63'(w_ay) * 63'(i_cfg.speed_limit);
                    end else begin
                        r_lvy <= r_vy[31] ? -$signed(w_qnext) : $signed(w_qnext);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        if (r_state == S_OUT && !r_reached && r_active) r_lw <= r_w;
                        r_oword.vel_x <= r_lvx; r_oword.vel_y <= r_lvy;
                        r_oword.turn_rate <= (!r_reached && r_active) ? r_w : r_lw;
                        r_oword.reached <= r_reached; r_oword.running <= r_active;
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/pose_pi_velocity_controller.sv]
// Top level of the pose PI velocity controller: APB register file, front
// queue and back-end sequencer. Depends on ppvc_pkg, ppvc_front, ppvc_back.
//
//  channel | signals                       | direction
//  input   | i_valid / o_stall / i_word    | in
//  output  | o_valid / i_stall / o_word    | out
//  config  | APB psel..pready              | in
//
// In the back end, a tick folds the heading error in up to three wrap steps,
// and vel_x/vel_y are rescaled, when either is over the speed limit, by the
// bit-serial divider, one axis after the other. Reset is synchronous and
// clears the control and state registers. The queue keeps taking words while
// the back end works or the output is stalled, until its two entries are full.
module pose_pi_velocity_controller #(
    parameter int POS_FRAC_BITS  = 16,
    parameter int GAIN_FRAC_BITS = 20,
    parameter int INTEG_WIDTH    = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ppvc_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output ppvc_pkg::t_out_word o_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ppvc_pkg::*;

    t_cfg     r_cfg;
    logic     w_qv, w_pop;
    t_in_word w_qw;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register file: write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_distance <= 31'd66;
            r_cfg.stop_angle    <= 31'd6862;
            r_cfg.speed_limit   <= 31'd65536;
            r_cfg.turn_limit    <= 31'd3276800;
            r_cfg.gain_prop     <= 31'd5242880;
            r_cfg.gain_integ    <= 31'd524;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_STOP_DIST:  r_cfg.stop_distance <= pwdata[30:0];
                REG_STOP_ANGLE: r_cfg.stop_angle    <= pwdata[30:0];
                REG_SPEED:      r_cfg.speed_limit   <= pwdata[30:0];
                REG_TURN:       r_cfg.turn_limit    <= pwdata[30:0];
                REG_GAIN_P:     r_cfg.gain_prop     <= pwdata[30:0];
                REG_GAIN_I:     r_cfg.gain_integ    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STOP_DIST:  prdata = {1'b0, r_cfg.stop_distance};
            REG_STOP_ANGLE: prdata = {1'b0, r_cfg.stop_angle};
            REG_SPEED:      prdata = {1'b0, r_cfg.speed_limit};
            REG_TURN:       prdata = {1'b0, r_cfg.turn_limit};
            REG_GAIN_P:     prdata = {1'b0, r_cfg.gain_prop};
            REG_GAIN_I:     prdata = {1'b0, r_cfg.gain_integ};
            default:        prdata = '0;
        endcase
    end

    ppvc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_word(w_qw)
    );

    ppvc_back #(
        .POS_FRAC_BITS(POS_FRAC_BITS), .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .INTEG_WIDTH(INTEG_WIDTH)
    ) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_word(w_qw), .o_valid, .i_stall, .o_word
    );
endmodule

[sv/ppvc_checker.sv]
// Port-level checker for the pose PI velocity controller, bound to the top.
// Depends on ppvc_pkg.
module ppvc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input ppvc_pkg::t_out_word o_word,
    input logic                pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word)) else $error("output dropped");
    a_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.reached |-> !o_word.running) else $error("reached while running");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.running && !o_word.reached |-> o_word.vel_x == 0
        && o_word.vel_y == 0 && o_word.turn_rate == 0) else $error("idle not zero");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind pose_pi_velocity_controller ppvc_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_word, .pready
);
